/* rtl/lfu_cache_lru_tiebreak_unit_defines.svh */
// assertion macros for the lfu cache checker
// expects clk and rst_n in the scope where a macro is used
`ifndef LFU_CACHE_LRU_TIEBREAK_UNIT_DEFINES_SVH
`define LFU_CACHE_LRU_TIEBREAK_UNIT_DEFINES_SVH

// same-cycle implication
`define LFULRU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfulru check failed");

// next-cycle implication
`define LFULRU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfulru check failed");

`endif

/* rtl/lfulru_pkg.sv */
// shared types and constants of the lfu cache with lru tie-break
// no dependencies
`timescale 1ns / 1ps

package lfulru_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int KEY_W            = 32;
    localparam int DATA_W           = 32;
    localparam int COUNT_W          = 16;
    localparam int CAP_W            = 5;

    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_INIT = 16'd1;
    localparam logic [DATA_W-1:0]  MISS_VALUE = 32'hFFFF_FFFF;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

endpackage

/* rtl/lfulru_ifs.sv */
// valid/ready channel interfaces: request, response and capacity write
// depends on lfulru_pkg
`timescale 1ns / 1ps

interface lfulru_req_if;
    logic                                    valid;
    logic                                    ready;
    lfulru_pkg::cmd_t                        cmd;
    logic signed [lfulru_pkg::KEY_W-1:0]     key;
    logic signed [lfulru_pkg::DATA_W-1:0]    value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lfulru_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    hit;
    logic signed [lfulru_pkg::DATA_W-1:0]    read_value;
    logic                                    evicted;
    logic signed [lfulru_pkg::KEY_W-1:0]     evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lfulru_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lfulru_pkg::CAP_W-1:0]       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lfu_cache_lru_tiebreak_unit.sv */
// top level: fully associative lfu key-value store with lru tie-break
// depends on lfulru_pkg and the channel interfaces in lfulru_ifs.sv
`timescale 1ns / 1ps

// channels: req (cmd, key, value) in, rsp (hit, read_value, evicted,
// evicted_key) out, cfg writes capacity_in_use; all valid/ready, a beat
// moves when valid and ready are both high. cfg is always ready.
// a get returns the stored value on a hit, -1 on a miss; a put updates a
// present key or inserts a new one, evicting the lowest-count entry (oldest
// touched on equal counts) when full; a put at capacity zero does nothing.
// timing: a req beat lands in an input register; the lookup, victim tree
// and update are combinational from it and load the result register when
// that is empty or being taken; the response is shown from it. one beat per
// cycle is sustained while rsp is not held off, as the compute step holds
// the parallel key match and the count/rank minimum tree over all entries.
// stall: while rsp is held off the result register keeps its beat, the
// input register still takes one more beat, then req.ready drops.
// reset: all entries invalid, occupancy zero, capacity 16, both registers
// empty; no clearing pass is needed.
module lfu_cache_lru_tiebreak_unit
#(
    parameter int CAPACITY = lfulru_pkg::CAPACITY_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    lfulru_req_if.sink         req,
    lfulru_rsp_if.source       rsp,
    lfulru_cfg_if.sink         cfg
);

    localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW     = IW;
    localparam int OW     = $clog2(CAPACITY + 1);
    localparam int LEAVES = 1 << IW;
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int CW     = lfulru_pkg::COUNT_W;
    localparam int KW     = lfulru_pkg::KEY_W;
    localparam int DW     = lfulru_pkg::DATA_W;
    localparam int TW     = CW + RW;

    // control
    logic [lfulru_pkg::CAP_W-1:0]  cap_reg, cap_next;
    logic [OW-1:0]                 occ_reg, occ_next;
    logic                          a_valid_reg, a_valid_next;
    logic                          o_valid_reg, o_valid_next;
    logic [CAPACITY-1:0]           valid_reg, valid_next;

    // input register payload
    lfulru_pkg::cmd_t              a_cmd_reg;
    logic signed [KW-1:0]          a_key_reg;
    logic signed [DW-1:0]          a_value_reg;

    // entry storage
    logic [KW-1:0]                 key_reg   [CAPACITY];
    logic [KW-1:0]                 key_next  [CAPACITY];
    logic [DW-1:0]                 data_reg  [CAPACITY];
    logic [DW-1:0]                 data_next [CAPACITY];
    logic [CW-1:0]                 count_reg [CAPACITY];
    logic [CW-1:0]                 count_next[CAPACITY];
    logic [RW-1:0]                 rank_reg  [CAPACITY];
    logic [RW-1:0]                 rank_next [CAPACITY];

    // result register
    logic                          o_hit_reg, o_hit_next;
    logic signed [DW-1:0]          o_rd_reg, o_rd_next;
    logic                          o_ev_reg, o_ev_next;
    logic signed [KW-1:0]          o_evk_reg, o_evk_next;

    logic                          accept;
    logic                          advance;

    logic [CAPACITY-1:0]           match;
    logic                          hit_any;
    logic [RW-1:0]                 hit_rank;
    logic [DW-1:0]                 hit_data;
    logic [OW-1:0]                 cap_eff;
    logic                          is_get;
    logic                          do_put;
    logic                          do_insert;
    logic                          do_evict;
    logic                          do_alloc;
    logic                          do_touch;
    logic [CAPACITY-1:0]           vic_sel;
    logic [RW-1:0]                 vic_rank;
    logic [KW-1:0]                 vic_key;
    logic [CAPACITY-1:0]           free_mask;
    logic                          free_any;
    logic [IW-1:0]                 free_idx;
    logic [CAPACITY-1:0]           free_sel;

    // victim tree, heap order, leaves at the back
    logic                          node_vld[NODES];
    logic [TW-1:0]                 node_tag[NODES];
    logic [IW-1:0]                 node_idx[NODES];

    assign accept    = req.valid && req.ready;
    assign advance   = a_valid_reg && (!o_valid_reg || rsp.ready);
    assign req.ready = !a_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign rsp.valid       = o_valid_reg;
    assign rsp.hit         = o_hit_reg;
    assign rsp.read_value  = o_rd_reg;
    assign rsp.evicted     = o_ev_reg;
    assign rsp.evicted_key = o_evk_reg;

    // tag: lower count first, then higher rank (older) first
    genvar g;
    generate
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            if (g < CAPACITY)
            begin : g_real
                assign node_vld[LEAVES-1+g] = valid_reg[g];
                assign node_tag[LEAVES-1+g] = {count_reg[g], ~rank_reg[g]};
            end
            else
            begin : g_pad
                assign node_vld[LEAVES-1+g] = 1'b0;
                assign node_tag[LEAVES-1+g] = '0;
            end
            assign node_idx[LEAVES-1+g] = IW'(g);
        end
        for (g = 0; g < LEAVES - 1; g++)
        begin : g_node
            logic take_left;
            assign take_left = node_vld[2*g+1] &&
                (!node_vld[2*g+2] || (node_tag[2*g+1] <= node_tag[2*g+2]));
            assign node_vld[g] = node_vld[2*g+1] || node_vld[2*g+2];
            assign node_tag[g] = take_left ? node_tag[2*g+1] : node_tag[2*g+2];
            assign node_idx[g] = take_left ? node_idx[2*g+1] : node_idx[2*g+2];
        end
    endgenerate

    always_comb
    begin
        hit_rank = '0;
        hit_data = '0;
        vic_rank = '0;
        vic_key  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i]   = valid_reg[i] && (key_reg[i] == a_key_reg);
            vic_sel[i] = node_vld[0] && (node_idx[0] == IW'(i));
            if (match[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
                hit_data = hit_data | data_reg[i];
            end
            if (vic_sel[i])
            begin
                vic_rank = vic_rank | rank_reg[i];
                vic_key  = vic_key | key_reg[i];
            end
        end
        hit_any = |match;

        cap_eff   = (cap_reg > CAPACITY) ? OW'(CAPACITY) : OW'(cap_reg);
        is_get    = (a_cmd_reg == lfulru_pkg::CMD_GET);
        do_put    = (a_cmd_reg == lfulru_pkg::CMD_PUT) && (cap_eff != '0);
        do_insert = do_put && !hit_any;
        do_evict  = do_insert && (occ_reg >= cap_eff) && node_vld[0];
        do_touch  = hit_any && (is_get || do_put);

        // the victim's slot counts as free for the insert
        free_mask = ~valid_reg | (do_evict ? vic_sel : '0);
        free_any  = |free_mask;
        free_idx  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                free_idx = IW'(i);
            end
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            free_sel[i] = free_any && (free_idx == IW'(i));
        end
        do_alloc = do_insert && free_any;
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_next[i]   = key_reg[i];
            data_next[i]  = data_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];

            if (do_touch)
            begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
                if (match[i])
                begin
                    rank_next[i] = '0;
                    if (count_reg[i] != lfulru_pkg::COUNT_MAX)
                    begin
                        count_next[i] = count_reg[i] + CW'(1);
                    end
                    if (do_put)
                    begin
                        data_next[i] = a_value_reg;
                    end
                end
            end

            if (do_evict && vic_sel[i])
            begin
                valid_next[i] = 1'b0;
            end

            if (do_alloc)
            begin
                if (valid_reg[i] && !(do_evict && vic_sel[i]))
                begin
                    if (do_evict && (rank_reg[i] > vic_rank))
                    begin
                        rank_next[i] = rank_reg[i];
                    end
                    else
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
                if (free_sel[i])
                begin
                    valid_next[i] = 1'b1;
                    key_next[i]   = a_key_reg;
                    data_next[i]  = a_value_reg;
                    count_next[i] = lfulru_pkg::COUNT_INIT;
                    rank_next[i]  = '0;
                end
            end
        end

        if (do_alloc && !do_evict)
        begin
            occ_next = occ_reg + OW'(1);
        end
        else if (do_evict && !do_alloc && (occ_reg != '0))
        begin
            occ_next = occ_reg - OW'(1);
        end

        o_hit_next = do_touch;
        if (is_get)
        begin
            o_rd_next = hit_any ? hit_data : lfulru_pkg::MISS_VALUE;
        end
        else
        begin
            o_rd_next = '0;
        end
        o_ev_next  = do_evict;
        o_evk_next = do_evict ? vic_key : '0;

        a_valid_next = accept ? 1'b1 : (advance ? 1'b0 : a_valid_reg);
        o_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : o_valid_reg);
        cap_next     = cfg.valid ? cfg.data : cap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= lfulru_pkg::CAP_RESET;
            occ_reg     <= '0;
            valid_reg   <= '0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg     <= cap_next;
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
            if (advance)
            begin
                occ_reg   <= occ_next;
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_cmd_reg   <= req.cmd;
            a_key_reg   <= req.key;
            a_value_reg <= req.value;
        end
        if (advance)
        begin
            o_hit_reg <= o_hit_next;
            o_rd_reg  <= o_rd_next;
            o_ev_reg  <= o_ev_next;
            o_evk_reg <= o_evk_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                key_reg[i]   <= key_next[i];
                data_reg[i]  <= data_next[i];
                count_reg[i] <= count_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

endmodule

/* rtl/lfulru_checker.sv */
// port-level assertions for lfu_cache_lru_tiebreak_unit, bound to the top
// depends on lfulru_pkg and lfu_cache_lru_tiebreak_unit_defines.svh
`timescale 1ns / 1ps
`include "lfu_cache_lru_tiebreak_unit_defines.svh"

module lfulru_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_ready,
    input logic                                 rsp_valid,
    input logic                                 rsp_ready,
    input logic                                 rsp_hit,
    input logic signed [lfulru_pkg::DATA_W-1:0] rsp_read_value,
    input logic                                 rsp_evicted,
    input logic signed [lfulru_pkg::KEY_W-1:0]  rsp_evicted_key
);

    // a held-off beat stays on the port
    `LFULRU_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // an eviction only comes from a put of a new key
    `LFULRU_ASSERT_IMP(a_evict_is_put_miss, rsp_valid && rsp_evicted,
        !rsp_hit && (rsp_read_value == '0))

    // no victim, no victim key
    `LFULRU_ASSERT_IMP(a_evk_zero, rsp_valid && !rsp_evicted, rsp_evicted_key == '0)

    // input side only blocks behind a stalled result
    `LFULRU_ASSERT_IMP(a_block_on_stall, !req_ready, rsp_valid && !rsp_ready)

endmodule

bind lfu_cache_lru_tiebreak_unit lfulru_checker u_lfulru_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_read_value  (rsp.read_value),
    .rsp_evicted     (rsp.evicted),
    .rsp_evicted_key (rsp.evicted_key)
);
